FILE: hdl/base58_encoder_macros.svh
// Assertion shorthands used by the encoder datapath.
// Both forms sample on the rising clock and stay quiet while reset is asserted.
`ifndef BASE58_ENCODER_MACROS_SVH
`define BASE58_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define B58_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define B58_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/b58enc_pkg.sv
package b58enc_pkg;

    // Store geometry
    localparam int DIGIT_CAPACITY = 40;
    localparam int OUTPUT_LIMIT   = 36;
    localparam int CNT_W          = $clog2(DIGIT_CAPACITY + 1);
    localparam int ADDR_W         = $clog2(DIGIT_CAPACITY);

    // Field widths
    localparam int BYTE_W = 8;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W = 7;
    localparam int LZ_W = 6;
    // Leading zeros (up to 63) plus digits (up to 40)
    localparam int TOT_W = 7;

    // Digit arithmetic: carry + digit * 256 stays below 14848
    localparam int RADIX = 58;
    localparam int SUM_W = 14;
    localparam int RECIP = 1130;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W = SUM_W + 11;

    localparam logic [LZ_W-1:0]   ZERO_COUNT_MAX = 6'd63;
    localparam logic [CHAR_W-1:0] ZERO_MARK      = 7'h31;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic fold_step;
        logic check;
        logic emit_step;
    } b58_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fold_done;
        logic last_byte;
        logic check_error;
        logic emit_last;
    } b58_status_t;

    // Map one base-58 digit to its alphabet character
    function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [BYTE_W-1:0] t;
        t = {2'b00, d};
        // Each range is a run of consecutive ASCII codes
        if (d inside {[0:8]})
            t = t + 8'd49;
        else if (d inside {[9:16]})
            t = t + 8'd56;
        else if (d inside {[17:21]})
            t = t + 8'd57;
        else if (d inside {[22:32]})
            t = t + 8'd58;
        else if (d inside {[33:43]})
            t = t + 8'd64;
        else if (d inside {[44:57]})
            t = t + 8'd65;
        else
            t = {1'b0, ZERO_MARK};
        return t[CHAR_W-1:0];
    endfunction

endpackage

FILE: hdl/b58enc_datapath.sv
`include "base58_encoder_macros.svh"

module b58enc_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  b58enc_pkg::b58_cmd_t                cmd,
    output b58enc_pkg::b58_status_t             status,
    input  logic [b58enc_pkg::BYTE_W-1:0]       data_byte,
    input  logic                                end_of_message,
    output logic                                result_valid,
    output logic [b58enc_pkg::CHAR_W-1:0]       text_char,
    output logic                                final_char,
    output logic                                encode_error
);

    // Digit store, little-endian; read data is registered
    logic [b58enc_pkg::DIGIT_W-1:0] mem [b58enc_pkg::DIGIT_CAPACITY];
    logic [b58enc_pkg::DIGIT_W-1:0] rd_data_reg;
    logic [b58enc_pkg::ADDR_W-1:0]  rd_addr;
    logic                           wr_en;
    logic [b58enc_pkg::ADDR_W-1:0]  wr_addr;
    logic [b58enc_pkg::DIGIT_W-1:0] wr_data;

    // Message state
    logic [b58enc_pkg::CNT_W-1:0]   used_reg, used_next;
    logic [b58enc_pkg::LZ_W-1:0]    lz_reg, lz_next;
    logic                           nz_reg, nz_next;
    logic                           nzprev_reg, nzprev_next;
    logic                           ovf_reg, ovf_next;
    logic                           last_reg, last_next;

    // Fold sweep
    logic [b58enc_pkg::CNT_W-1:0]   idx_reg, idx_next;
    logic [b58enc_pkg::BYTE_W-1:0]  carry_reg, carry_next;

    // Text emission
    logic [b58enc_pkg::LZ_W-1:0]    zl_reg, zl_next;
    logic [b58enc_pkg::CNT_W-1:0]   dl_reg, dl_next;
    logic [b58enc_pkg::ADDR_W-1:0]  rd_idx_reg, rd_idx_next;

    // Result beat
    logic                           rv_reg, rv_next;
    logic [b58enc_pkg::CHAR_W-1:0]  ch_reg, ch_next;
    logic                           fin_reg, fin_next;
    logic                           err_reg, err_next;

    // Digit unit
    logic                           in_use;
    logic [b58enc_pkg::CNT_W-1:0]   idx_inc;
    logic                           cont_in_use;
    logic                           at_cap;
    logic [b58enc_pkg::DIGIT_W-1:0] digit_in;
    logic [b58enc_pkg::SUM_W-1:0]   sum;
    logic [b58enc_pkg::PROD_W-1:0]  prod;
    logic [b58enc_pkg::BYTE_W-1:0]  quot;
    logic [b58enc_pkg::SUM_W-1:0]   quot_x58;
    logic [b58enc_pkg::SUM_W-1:0]   rem_full;

    // Final check and emission
    logic [b58enc_pkg::CNT_W-1:0]   used_trim;
    logic [b58enc_pkg::TOT_W-1:0]   total;
    logic                           check_err;
    logic                           emit_final;

    // Split carry + digit * 256 by 58 with a reciprocal multiply
    always_comb
    begin
        in_use      = idx_reg < used_reg;
        idx_inc     = idx_reg + b58enc_pkg::CNT_W'(1);
        cont_in_use = idx_inc < used_reg;
        at_cap      = idx_inc == b58enc_pkg::CNT_W'(b58enc_pkg::DIGIT_CAPACITY);
        // Before any nonzero byte the value is zero, whatever the store holds
        digit_in    = (in_use && nzprev_reg) ? rd_data_reg : '0;
        sum         = {digit_in, b58enc_pkg::BYTE_W'(0)}
                      + b58enc_pkg::SUM_W'(carry_reg);
        prod        = b58enc_pkg::PROD_W'(sum) * b58enc_pkg::PROD_W'(b58enc_pkg::RECIP);
        quot        = prod[b58enc_pkg::RECIP_SHIFT +: b58enc_pkg::BYTE_W];
        quot_x58    = b58enc_pkg::SUM_W'(quot) * b58enc_pkg::SUM_W'(b58enc_pkg::RADIX);
        rem_full    = sum - quot_x58;
    end

    // The top digit is nonzero once any nonzero byte is folded, so trimming
    // only drops the lone zero digit of an all-zero message
    always_comb
    begin
        used_trim  = nz_reg ? used_reg : '0;
        total      = b58enc_pkg::TOT_W'(lz_reg) + b58enc_pkg::TOT_W'(used_trim);
        check_err  = ovf_reg || (total >= b58enc_pkg::TOT_W'(b58enc_pkg::OUTPUT_LIMIT));
        emit_final = ((zl_reg == b58enc_pkg::LZ_W'(1)) && (dl_reg == '0))
                     || ((zl_reg == '0) && (dl_reg == b58enc_pkg::CNT_W'(1)));
    end

    always_comb
    begin
        status.fold_done   = ovf_reg || (!cont_in_use && ((quot == '0) || at_cap));
        status.last_byte   = last_reg;
        status.check_error = check_err;
        status.emit_last   = emit_final;
    end

    // Next-state logic
    always_comb
    begin
        used_next   = used_reg;
        lz_next     = lz_reg;
        nz_next     = nz_reg;
        nzprev_next = nzprev_reg;
        ovf_next    = ovf_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        carry_next  = carry_reg;
        zl_next     = zl_reg;
        dl_next     = dl_reg;
        rd_idx_next = rd_idx_reg;
        rv_next     = 1'b0;
        ch_next     = ch_reg;
        fin_next    = fin_reg;
        err_next    = err_reg;
        rd_addr     = rd_idx_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg[b58enc_pkg::ADDR_W-1:0];
        wr_data     = rem_full[b58enc_pkg::DIGIT_W-1:0];

        if (cmd.accept)
        begin
            // Count leading zeros, then start the sweep at digit zero
            nzprev_next = nz_reg;
            if (!nz_reg)
            begin
                if (data_byte == '0)
                begin
                    if (lz_reg == b58enc_pkg::ZERO_COUNT_MAX)
                        ovf_next = 1'b1;
                    else
                        lz_next = lz_reg + b58enc_pkg::LZ_W'(1);
                end
                else
                begin
                    nz_next = 1'b1;
                end
            end
            last_next  = end_of_message;
            carry_next = data_byte;
            idx_next   = '0;
            rd_addr    = '0;
        end
        else if (cmd.fold_step)
        begin
            // Fold one digit and fetch the next
            if (!ovf_reg)
            begin
                wr_en      = 1'b1;
                carry_next = quot;
                idx_next   = idx_inc;
                if (!in_use)
                    used_next = idx_inc;
                if (!cont_in_use && (quot != '0) && at_cap)
                    ovf_next = 1'b1;
            end
            if (cont_in_use || !at_cap)
                rd_addr = idx_inc[b58enc_pkg::ADDR_W-1:0];
            else
                rd_addr = '0;
        end
        else if (cmd.check)
        begin
            if (check_err)
            begin
                rv_next  = 1'b1;
                ch_next  = '0;
                fin_next = 1'b1;
                err_next = 1'b1;
            end
            else
            begin
                zl_next = lz_reg;
                dl_next = used_trim;
            end
            // Prefetch the top digit
            if (used_trim == '0)
                rd_idx_next = '0;
            else
                rd_idx_next = b58enc_pkg::ADDR_W'(used_trim - b58enc_pkg::CNT_W'(1));
            rd_addr = rd_idx_next;
        end
        else if (cmd.emit_step)
        begin
            rv_next  = 1'b1;
            fin_next = emit_final;
            err_next = 1'b0;
            if (zl_reg != '0)
            begin
                ch_next = b58enc_pkg::ZERO_MARK;
                zl_next = zl_reg - b58enc_pkg::LZ_W'(1);
            end
            else
            begin
                ch_next = b58enc_pkg::b58_char(rd_data_reg);
                dl_next = dl_reg - b58enc_pkg::CNT_W'(1);
                if (rd_idx_reg != '0)
                    rd_idx_next = rd_idx_reg - b58enc_pkg::ADDR_W'(1);
                rd_addr = rd_idx_next;
            end
        end

        // Return to an empty message after the last beat
        if ((cmd.check && check_err) || (cmd.emit_step && emit_final))
        begin
            used_next = b58enc_pkg::CNT_W'(1);
            lz_next   = '0;
            nz_next   = 1'b0;
            ovf_next  = 1'b0;
        end
    end

    // Digit store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= b58enc_pkg::CNT_W'(1);
            lz_reg     <= '0;
            nz_reg     <= 1'b0;
            nzprev_reg <= 1'b0;
            ovf_reg    <= 1'b0;
            last_reg   <= 1'b0;
            idx_reg    <= '0;
            carry_reg  <= '0;
            zl_reg     <= '0;
            dl_reg     <= '0;
            rd_idx_reg <= '0;
            rv_reg     <= 1'b0;
            ch_reg     <= '0;
            fin_reg    <= 1'b0;
            err_reg    <= 1'b0;
        end
        else
        begin
            used_reg   <= used_next;
            lz_reg     <= lz_next;
            nz_reg     <= nz_next;
            nzprev_reg <= nzprev_next;
            ovf_reg    <= ovf_next;
            last_reg   <= last_next;
            idx_reg    <= idx_next;
            carry_reg  <= carry_next;
            zl_reg     <= zl_next;
            dl_reg     <= dl_next;
            rd_idx_reg <= rd_idx_next;
            rv_reg     <= rv_next;
            ch_reg     <= ch_next;
            fin_reg    <= fin_next;
            err_reg    <= err_next;
        end
    end

    assign result_valid = rv_reg;
    assign text_char    = ch_reg;
    assign final_char   = fin_reg;
    assign encode_error = err_reg;

    `B58_ASSERT_SAME(a_fold_in_range, cmd.fold_step && !ovf_reg,
        idx_reg < b58enc_pkg::CNT_W'(b58enc_pkg::DIGIT_CAPACITY),
        "fold step past the end of the digit store")
    `B58_ASSERT_SAME(a_used_bounds, 1'b1,
        (used_reg != '0) && (used_reg <= b58enc_pkg::CNT_W'(b58enc_pkg::DIGIT_CAPACITY)),
        "digit count out of range")
    `B58_ASSERT_SAME(a_error_beat, rv_reg && err_reg,
        fin_reg && (ch_reg == '0),
        "error beat must be final and carry no character")
    `B58_ASSERT_SAME(a_cleared_after_final, rv_reg && fin_reg,
        (used_reg == b58enc_pkg::CNT_W'(1)) && (lz_reg == '0) && !nz_reg && !ovf_reg,
        "message state not cleared after the final beat")

endmodule

FILE: hdl/b58enc_ctrl.sv
module b58enc_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    output b58enc_pkg::b58_cmd_t     cmd,
    input  b58enc_pkg::b58_status_t  status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FOLD,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    // Decode commands and the next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold_step = 1'b1;
                if (status.fold_done)
                    state_next = status.last_byte ? S_CHECK : S_IDLE;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.check_error ? S_IDLE : S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_step = 1'b1;
                if (status.emit_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != S_IDLE;
        end
    end

    assign busy = busy_reg;

endmodule

FILE: hdl/base58_encoder.sv
// Channel   Signals                                      Beat taken when
// ------    -------------------------------------------  ---------------------------
// input     start, busy, data_byte, end_of_message        start high, busy low
// result    result_valid, text_char, final_char,          every cycle result_valid
//           encode_error                                  is high
//
// A byte is taken in an accept step, then folded one digit a cycle through the
// single divide-by-58 unit, behind the registered read port, over the digits in
// use after folding it (at most 40); once the message has overflowed, its folds
// write no digit. A final byte then adds a check step and one character per
// cycle (an error beat comes from the check step); busy drops as the last beat shows.
// Reset is asynchronous, active low; the receiver cannot stall.
module base58_encoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [b58enc_pkg::BYTE_W-1:0]       data_byte,
    input  logic                                end_of_message,
    output logic                                result_valid,
    output logic [b58enc_pkg::CHAR_W-1:0]       text_char,
    output logic                                final_char,
    output logic                                encode_error
);

    b58enc_pkg::b58_cmd_t    cmd;
    b58enc_pkg::b58_status_t status;

    b58enc_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    b58enc_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .result_valid   (result_valid),
        .text_char      (text_char),
        .final_char     (final_char),
        .encode_error   (encode_error)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int HALF_PERIOD = 10;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 100;
    localparam int PHASE_ITEMS = 3;

    // One message byte waiting to be offered, with the sender idle odds before it
    typedef struct {
        logic [b58enc_pkg::BYTE_W-1:0] data;
        logic                          last;
        int                            idle_pct;
    } msg_byte_t;

    // One character beat of the encoded text
    typedef struct {
        logic [b58enc_pkg::CHAR_W-1:0] ch;
        logic                          fin;
        logic                          err;
    } text_beat_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic [b58enc_pkg::BYTE_W-1:0] data_byte = '0;
    logic                          end_of_message = 1'b0;
    logic                          busy;
    logic                          result_valid;
    logic [b58enc_pkg::CHAR_W-1:0] text_char;
    logic                          final_char;
    logic                          encode_error;

    msg_byte_t  pending_bytes[$];
    text_beat_t expected_text[$];
    logic       byte_taken = 1'b0;
    int         error_count = 0;
    int         quiet_cycles = 0;

    // Shadow of the encoder's message state
    logic [b58enc_pkg::DIGIT_W-1:0] shadow_digits [b58enc_pkg::DIGIT_CAPACITY];
    int                             shadow_used;
    int                             shadow_zeros;
    bit                             shadow_nonzero;
    bit                             shadow_overflow;
    string alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    base58_encoder u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .result_valid   (result_valid),
        .text_char      (text_char),
        .final_char     (final_char),
        .encode_error   (encode_error)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("MISMATCH %s: got 0x%h, want 0x%h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic void clear_shadow();
        foreach (shadow_digits[i])
            shadow_digits[i] = '0;
        shadow_used = 1;
        shadow_zeros = 0;
        shadow_nonzero = 1'b0;
        shadow_overflow = 1'b0;
    endfunction

    // Multiply the digit store by 256 and add the byte, digit by digit
    function automatic void fold_into_shadow(input logic [b58enc_pkg::BYTE_W-1:0] b);
        int unsigned carry;
        carry = b;
        for (int j = 0; j < shadow_used; j++)
        begin
            carry = carry + int'(shadow_digits[j]) * 256;
            shadow_digits[j] = b58enc_pkg::DIGIT_W'(carry % b58enc_pkg::RADIX);
            carry = carry / b58enc_pkg::RADIX;
        end
        while (carry != 0)
        begin
            if (shadow_used >= b58enc_pkg::DIGIT_CAPACITY)
            begin
                shadow_overflow = 1'b1;
                return;
            end
            shadow_digits[shadow_used] = b58enc_pkg::DIGIT_W'(carry % b58enc_pkg::RADIX);
            shadow_used++;
            carry = carry / b58enc_pkg::RADIX;
        end
    endfunction

    // Advance the shadow by one byte; on the final byte queue the expected text
    function automatic void encode_byte(input logic [b58enc_pkg::BYTE_W-1:0] b,
                                        input logic last);
        int         n_digits;
        int         total;
        int         k;
        text_beat_t beat;
        if (!shadow_nonzero)
        begin
            if (b == 0)
            begin
                if (shadow_zeros >= b58enc_pkg::ZERO_COUNT_MAX)
                    shadow_overflow = 1'b1;
                else
                    shadow_zeros++;
            end
            else
                shadow_nonzero = 1'b1;
        end
        if (!shadow_overflow)
            fold_into_shadow(b);
        if (!last)
            return;

        // Trim high zero digits
        n_digits = shadow_used;
        while (n_digits > 0 && shadow_digits[n_digits-1] == 0)
            n_digits--;

        if (shadow_overflow || shadow_zeros + n_digits >= b58enc_pkg::OUTPUT_LIMIT)
        begin
            beat.ch = '0;
            beat.fin = 1'b1;
            beat.err = 1'b1;
            expected_text.push_back(beat);
        end
        else
        begin
            total = shadow_zeros + n_digits;
            k = 0;
            beat.err = 1'b0;
            for (int z = 0; z < shadow_zeros; z++)
            begin
                beat.ch = b58enc_pkg::ZERO_MARK;
                beat.fin = (k + 1 == total);
                expected_text.push_back(beat);
                k++;
            end
            for (int d = n_digits - 1; d >= 0; d--)
            begin
                beat.ch = b58enc_pkg::CHAR_W'(alphabet[int'(shadow_digits[d])]);
                beat.fin = (k + 1 == total);
                expected_text.push_back(beat);
                k++;
            end
        end
        clear_shadow();
    endfunction

    task automatic add_byte(input logic [b58enc_pkg::BYTE_W-1:0] b, input logic last,
                            input int pct);
        msg_byte_t item;
        item.data = b;
        item.last = last;
        item.idle_pct = pct;
        pending_bytes.push_back(item);
    endtask

    // Long message whose first byte is at least lead_min, rest random
    task automatic add_wide_message(input int n_bytes, input int lead_min, input int pct);
        add_byte(b58enc_pkg::BYTE_W'($urandom_range(255, lead_min)), 1'b0, pct);
        for (int i = 1; i < n_bytes; i++)
            add_byte(b58enc_pkg::BYTE_W'($urandom_range(255)), i == n_bytes - 1, pct);
    endtask

    // Offer the next byte once the previous one is taken
    always @(negedge clk)
    begin : driver
        msg_byte_t nxt;
        if (rst_n && (!start || byte_taken))
        begin
            if (pending_bytes.size() != 0 &&
                $urandom_range(99) >= pending_bytes[0].idle_pct)
            begin
                nxt = pending_bytes.pop_front();
                start <= 1'b1;
                data_byte <= nxt.data;
                end_of_message <= nxt.last;
            end
            else
                start <= 1'b0;
        end
    end

    // Check result beats, predict accepted input beats
    always @(posedge clk)
    begin : monitor
        text_beat_t want;
        byte_taken <= rst_n && start && !busy;
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (expected_text.size() == 0)
                    report_mismatch("unexpected result beat", 8'(text_char), 8'h00);
                else
                begin
                    want = expected_text.pop_front();
                    if (text_char !== want.ch)
                        report_mismatch("text_char", 8'(text_char), 8'(want.ch));
                    if (final_char !== want.fin)
                        report_mismatch("final_char", 8'(final_char), 8'(want.fin));
                    if (encode_error !== want.err)
                        report_mismatch("encode_error", 8'(encode_error), 8'(want.err));
                end
            end
            if (start && !busy)
                encode_byte(data_byte, end_of_message);
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int pct;
        int phase_items;
        int n_zeros;
        int n_body;
        clear_shadow();

        // Directed: single-byte extremes, leading zeros, zero after nonzero
        add_byte(8'h00, 1'b1, 0);
        add_byte(8'hFF, 1'b1, 0);
        add_byte(8'h01, 1'b1, 0);
        add_byte(8'h39, 1'b1, 0);
        add_byte(8'h3A, 1'b1, 0);
        add_byte(8'h80, 1'b1, 0);
        add_byte(8'h00, 1'b0, 0);
        add_byte(8'h00, 1'b0, 0);
        add_byte(8'h01, 1'b1, 0);
        add_byte(8'h01, 1'b0, 0);
        add_byte(8'h00, 1'b1, 0);
        add_byte(8'h00, 1'b0, 0);
        add_byte(8'h00, 1'b1, 0);
        add_byte(8'h55, 1'b0, 0);
        add_byte(8'hAA, 1'b1, 0);

        // Random phases; the first three each carry one long message at a limit
        for (int phase = 0; phase < 4; phase++)
        begin
            pct = (phase == 1) ? 57 : (phase == 3) ? 37 : 0;
            case (phase)
                0: add_wide_message(25, 8'hC0, pct);   // longest text that fits
                1: add_wide_message(27, 8'h80, pct);   // text too long
                2: add_wide_message(30, 8'h80, pct);   // digit store overflow
                default: ;                             // short messages only
            endcase

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                if ($urandom_range(9) == 0)
                begin
                    // all-zero message
                    n_body = $urandom_range(4, 1);
                    for (int i = 0; i < n_body; i++)
                        add_byte(8'h00, i == n_body - 1, pct);
                    phase_items += n_body;
                end
                else
                begin
                    n_zeros = ($urandom_range(2) == 0) ? $urandom_range(3, 1) : 0;
                    n_body = $urandom_range(6, 1);
                    for (int i = 0; i < n_zeros; i++)
                        add_byte(8'h00, 1'b0, pct);
                    for (int i = 0; i < n_body; i++)
                        add_byte(($urandom_range(7) == 0) ? 8'h00 :
                                 b58enc_pkg::BYTE_W'($urandom_range(255, 1)),
                                 i == n_body - 1, pct);
                    phase_items += n_zeros + n_body;
                end
            end
        end

        // Hold reset, then release it away from the sampling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for all bytes taken and all text seen, then let the block settle
        while (pending_bytes.size() != 0 || start)
            @(posedge clk);
        while (expected_text.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_text.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/b58enc_pkg.sv
hdl/b58enc_datapath.sv
hdl/b58enc_ctrl.sv
hdl/base58_encoder.sv
tb/tb.sv
